[rtl/lru_address_tag_store_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the LRU address tag store.
// Define ASSERT_OFF to compile the checks away.
// ---------------------------------------------------------------------------
`ifndef LRU_ADDRESS_TAG_STORE_DEFINES_SVH
`define LRU_ADDRESS_TAG_STORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Implication checked at every rising clock edge, held off during reset.
`define LATS_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Plain invariant checked at every rising clock edge, held off during reset.
`define LATS_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

`else

`define LATS_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define LATS_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)

`endif

`endif

[rtl/lats_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lats_pkg
// Shared widths, request codes and types of the LRU address tag store.
// ---------------------------------------------------------------------------
package lats_pkg;

	localparam int ADDR_W      = 32;
	localparam int SLOT_W      = 4;
	localparam int TOTAL_W     = 5;
	localparam int ENTRIES_DEF = 16;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [TOTAL_W-1:0] total_t;

	// Request codes
	typedef enum logic [1:0] {
		KIND_SET    = 2'd0,
		KIND_FIND   = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_e;

endpackage

[rtl/lats_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lats_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lats_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/lru_address_tag_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru_address_tag_store
// Fully associative store of buffer addresses kept in most-recently-used
// order. Addresses sit in a RAM that is scanned per request; live bits and
// age ranks sit in flops and update in parallel when the request commits.
//
//   channel | signals                           | direction
//   --------+-----------------------------------+----------
//   in      | in_valid, in_ready, kind, address | into block
//   out     | out_valid, out_ready, hit, slot,  | out of block
//           | slot_valid, evicted,              |
//           | evicted_address, entry_total      |
//
// Clear skips the scan and goes straight to the finish state. Other requests
// scan the address RAM one entry per cycle through its single read port,
// stopping at the first hit or after the last entry.
// One request is in flight at a time; in_ready is high only when idle.
// A finished result waits in the output register while the next beat is
// accepted; commit of that next request waits while the register is full.
// Asynchronous reset empties the store; the RAM needs no clearing.
// ---------------------------------------------------------------------------
`include "lru_address_tag_store_defines.svh"

module lru_address_tag_store #(
	parameter int ENTRIES = lats_pkg::ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lats_pkg::kind_e  kind,
	input  lats_pkg::addr_t  address,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             hit,
	output lats_pkg::slot_t  slot,
	output logic             slot_valid,
	output logic             evicted,
	output lats_pkg::addr_t  evicted_address,
	output lats_pkg::total_t entry_total
);

	import lats_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_e;

	// Control state
	state_e              state_q;
	kind_e               kind_q;
	logic                issue_on_q;
	idx_t                issue_idx_q;
	logic                rd_vld_s1;
	idx_t                rd_idx_s1;
	logic                hit_q;
	idx_t                slot_q;
	logic                vic_found_q;
	idx_t                vic_slot_q;
	logic                free_found_q;
	idx_t                free_slot_q;
	logic [ENTRIES-1:0]  live_q;
	idx_t                rank_q [ENTRIES];
	cnt_t                live_cnt_q;
	logic                out_valid_q;

	// Payload registers
	addr_t               addr_q;
	addr_t               vic_addr_q;
	logic                o_hit_q;
	slot_t               o_slot_q;
	logic                o_sv_q;
	logic                o_ev_q;
	addr_t               o_evaddr_q;
	total_t              o_total_q;

	// Combinational
	logic                accept;
	logic                commit;
	logic                ram_re;
	addr_t               ram_rdata;
	logic                ram_we;
	logic                cmp_match;
	logic                cmp_last;
	logic                cmp_victim;
	logic                full;
	idx_t                ins_slot;
	idx_t                sel_rank;
	logic [ENTRIES-1:0]  live_n;
	idx_t                rank_n [ENTRIES];
	cnt_t                cnt_n;
	logic                o_hit_n;
	idx_t                o_slot_n;
	logic                o_sv_n;
	logic                o_ev_n;
	addr_t               o_evaddr_n;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign commit   = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// Address RAM: scanned in ST_SCAN, written when an insert commits
	assign ram_re = (state_q == ST_SCAN) && issue_on_q;

	lats_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (ENTRIES)
	) u_addr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ins_slot),
		.wdata (addr_q),
		.re    (ram_re),
		.raddr (issue_idx_q),
		.rdata (ram_rdata)
	);

	// Compare stage of the scan
	assign cmp_match  = rd_vld_s1 && live_q[rd_idx_s1] && (ram_rdata == addr_q);
	assign cmp_last   = (rd_idx_s1 == idx_t'(ENTRIES - 1));
	assign cmp_victim = live_q[rd_idx_s1] && (rank_q[rd_idx_s1] == idx_t'(ENTRIES - 1));

	assign full     = (live_cnt_q >= cnt_t'(ENTRIES));
	assign ins_slot = full ? vic_slot_q : free_slot_q;
	assign sel_rank = rank_q[slot_q];
	assign ram_we   = commit && (kind_q == KIND_SET) && !hit_q;

	// Next live bits, ranks, count and result fields at commit
	always_comb begin
		live_n     = live_q;
		rank_n     = rank_q;
		cnt_n      = live_cnt_q;
		o_hit_n    = 1'b0;
		o_slot_n   = '0;
		o_sv_n     = 1'b0;
		o_ev_n     = 1'b0;
		o_evaddr_n = '0;
		case (kind_q)
			KIND_CLEAR: begin
				live_n = '0;
				for (int i = 0; i < ENTRIES; i++) begin
					rank_n[i] = '0;
				end
				cnt_n = '0;
			end
			KIND_FIND: begin
				if (hit_q) begin
					o_hit_n  = 1'b1;
					o_slot_n = slot_q;
					o_sv_n   = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (hit_q) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (live_q[i] && (rank_q[i] > sel_rank)) begin
							rank_n[i] = rank_q[i] - idx_t'(1);
						end
					end
					live_n[slot_q] = 1'b0;
					rank_n[slot_q] = '0;
					cnt_n          = live_cnt_q - cnt_t'(1);
					o_hit_n        = 1'b1;
					o_slot_n       = slot_q;
				end
			end
			KIND_SET: begin
				if (hit_q) begin
					// promote to most recent
					for (int i = 0; i < ENTRIES; i++) begin
						if (live_q[i] && (rank_q[i] < sel_rank)) begin
							rank_n[i] = rank_q[i] + idx_t'(1);
						end
					end
					rank_n[slot_q] = '0;
					o_hit_n        = 1'b1;
					o_slot_n       = slot_q;
					o_sv_n         = 1'b1;
				end else begin
					// insert, evicting the oldest when full
					for (int i = 0; i < ENTRIES; i++) begin
						if (live_q[i] && !(full && (idx_t'(i) == ins_slot))) begin
							rank_n[i] = rank_q[i] + idx_t'(1);
						end
					end
					live_n[ins_slot] = 1'b1;
					rank_n[ins_slot] = '0;
					cnt_n            = full ? live_cnt_q : live_cnt_q + cnt_t'(1);
					o_slot_n         = ins_slot;
					o_sv_n           = 1'b1;
					o_ev_n           = full;
					o_evaddr_n       = full ? vic_addr_q : '0;
				end
			end
			default: begin
				live_n = live_q;
			end
		endcase
	end

	// Sequencer, scan bookkeeping and store state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= KIND_SET;
			issue_on_q   <= 1'b0;
			issue_idx_q  <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			hit_q        <= 1'b0;
			slot_q       <= '0;
			vic_found_q  <= 1'b0;
			vic_slot_q   <= '0;
			free_found_q <= 1'b0;
			free_slot_q  <= '0;
			live_q       <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
			live_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_ready && !commit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q       <= kind;
						issue_on_q   <= 1'b1;
						issue_idx_q  <= '0;
						rd_vld_s1    <= 1'b0;
						hit_q        <= 1'b0;
						slot_q       <= '0;
						vic_found_q  <= 1'b0;
						vic_slot_q   <= '0;
						free_found_q <= 1'b0;
						free_slot_q  <= '0;
						state_q      <= (kind == KIND_CLEAR) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// read issue
					if (issue_on_q) begin
						issue_idx_q <= issue_idx_q + idx_t'(1);
						if (issue_idx_q == idx_t'(ENTRIES - 1)) begin
							issue_on_q <= 1'b0;
						end
					end
					rd_vld_s1 <= issue_on_q;
					rd_idx_s1 <= issue_idx_q;
					// compare; rd_vld_s1 is only looked at while scanning
					if (rd_vld_s1) begin
						if (!vic_found_q && (cmp_victim || (rd_idx_s1 == '0))) begin
							vic_slot_q <= rd_idx_s1;
						end
						if (cmp_victim) begin
							vic_found_q <= 1'b1;
						end
						if (!free_found_q && !live_q[rd_idx_s1]) begin
							free_found_q <= 1'b1;
							free_slot_q  <= rd_idx_s1;
						end
						if (cmp_match) begin
							hit_q   <= 1'b1;
							slot_q  <= rd_idx_s1;
							state_q <= ST_FINISH;
						end else if (cmp_last) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (commit) begin
						live_q      <= live_n;
						rank_q      <= rank_n;
						live_cnt_q  <= cnt_n;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload: request address, victim address, result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= address;
		end
		if ((state_q == ST_SCAN) && rd_vld_s1 && !vic_found_q
			&& (cmp_victim || (rd_idx_s1 == '0))) begin
			vic_addr_q <= ram_rdata;
		end
		if (commit) begin
			o_hit_q    <= o_hit_n;
			o_slot_q   <= slot_t'(o_slot_n);
			o_sv_q     <= o_sv_n;
			o_ev_q     <= o_ev_n;
			o_evaddr_q <= o_evaddr_n;
			o_total_q  <= total_t'(cnt_n);
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = o_hit_q;
	assign slot            = o_slot_q;
	assign slot_valid      = o_sv_q;
	assign evicted         = o_ev_q;
	assign evicted_address = o_evaddr_q;
	assign entry_total     = o_total_q;

	// Checks
	`LATS_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, live_cnt_q <= cnt_t'(ENTRIES), "count high")
	`LATS_ASSERT_ALWAYS(a_cnt_pop, clk, arst_n, $countones(live_q) == int'(live_cnt_q), "count off")
	`LATS_ASSERT_IMP(a_we_insert, clk, arst_n, ram_we, (state_q == ST_FINISH) && !hit_q, "bad write")
	`LATS_ASSERT_IMP(a_hit_live, clk, arst_n, (state_q == ST_FINISH) && hit_q, live_q[slot_q], "dead hit")
	`LATS_ASSERT_IMP(a_out_rise, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_FINISH), "no commit")

endmodule
